FILE: hdl/bhp_pkg.sv
// Shared types and constants for the BMP header parser.
// Used by bhp_fields, bhp_result and bmp_header_parser_top; depends on nothing.

package bhp_pkg;

    // Signature bytes
    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;

    // Header size codes
    localparam logic [31:0] HDR_CORE     = 32'd12;
    localparam logic [31:0] HDR_INFO_MIN = 32'd40;

    // Byte offsets within the file
    localparam logic [5:0] OFS_HDR_SIZE0 = 6'd14;
    localparam logic [5:0] OFS_HDR_SIZE1 = 6'd15;
    localparam logic [5:0] OFS_HDR_SIZE2 = 6'd16;
    localparam logic [5:0] OFS_HDR_SIZE3 = 6'd17;
    localparam logic [5:0] OFS_FIELD18   = 6'd18;
    localparam logic [5:0] OFS_FIELD19   = 6'd19;
    localparam logic [5:0] OFS_FIELD20   = 6'd20;
    localparam logic [5:0] OFS_FIELD21   = 6'd21;
    localparam logic [5:0] OFS_FIELD22   = 6'd22;
    localparam logic [5:0] OFS_FIELD23   = 6'd23;
    localparam logic [5:0] OFS_FIELD24   = 6'd24;
    localparam logic [5:0] OFS_FIELD25   = 6'd25;
    localparam logic [5:0] OFS_DEPTH0    = 6'd28;
    localparam logic [5:0] OFS_DEPTH1    = 6'd29;
    localparam logic [5:0] OFS_COMP0     = 6'd30;
    localparam logic [5:0] OFS_COMP1     = 6'd31;
    localparam logic [5:0] OFS_COMP2     = 6'd32;
    localparam logic [5:0] OFS_COMP3     = 6'd33;
    localparam logic [5:0] OFS_COLORS0   = 6'd46;
    localparam logic [5:0] OFS_COLORS1   = 6'd47;
    localparam logic [5:0] OFS_COLORS2   = 6'd48;
    localparam logic [5:0] OFS_COLORS3   = 6'd49;
    localparam logic [5:0] OFS_MIN_LEN   = 6'd17;  // last offset of an 18-byte stream
    localparam logic [5:0] OFS_CORE_LEN  = 6'd25;  // last offset of a 26-byte stream
    localparam logic [5:0] OFS_CORE_PAL  = 6'd26;
    localparam logic [5:0] OFS_INFO_LEN  = 6'd49;  // last offset of a 50-byte stream
    localparam logic [5:0] INFO_PAL_BASE = 6'd14;

    // Palette limits
    localparam logic [15:0] PAL_MAX_DEPTH = 16'd8;

    // Compression codes
    localparam logic [31:0] COMP_RGB       = 32'd0;
    localparam logic [31:0] COMP_RLE8      = 32'd1;
    localparam logic [31:0] COMP_BITFIELDS = 32'd3;

    // Bit depths with a fixed channel count
    localparam logic [15:0] BPP_16 = 16'd16;
    localparam logic [15:0] BPP_24 = 16'd24;
    localparam logic [15:0] BPP_32 = 16'd32;

    // Header kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CORE = 2'd1;
    localparam logic [1:0] KIND_INFO = 2'd2;

    // Channel counts
    localparam logic [2:0] CH_NONE = 3'd0;
    localparam logic [2:0] CH_GRAY = 3'd1;
    localparam logic [2:0] CH_RGB  = 3'd3;
    localparam logic [2:0] CH_RGBA = 3'd4;

    // Header state after the current byte, plus stream length flags
    typedef struct packed {
        logic        signature_ok;
        logic [31:0] header_length;
        logic [31:0] width_word;
        logic [31:0] height_word;
        logic [15:0] depth_word;
        logic [31:0] compression_word;
        logic [31:0] colors_word;
        logic        color_seen;
        logic        len_ge18;
        logic        len_ge26;
        logic        len_ge50;
    } bhp_snap_t;

    // Result item; last field in the lowest bits
    typedef struct packed {
        logic [2:0]  channels;
        logic [31:0] compression;
        logic [15:0] bits_per_pixel;
        logic [31:0] image_height;
        logic [31:0] image_width;
        logic [1:0]  header_kind;
        logic        status;
        logic        can_parse;
    } bhp_result_t;

    localparam int RESULT_BITS = $bits(bhp_result_t);
    localparam int TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

endpackage

FILE: hdl/bhp_fields.sv
// Byte offset counter, header field capture and palette scan.
// Depends on bhp_pkg; instantiated by bmp_header_parser_top.

module bhp_fields #(
    parameter int OFFSET_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        data_byte,
    input  logic              last,
    output bhp_pkg::bhp_snap_t snap
);

    localparam int CMP_W = ((OFFSET_BITS > 33) ? OFFSET_BITS : 33) + 1;

    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic                   sig_reg, sig_next;
    logic [31:0]            hl_reg, hl_next;
    logic [31:0]            width_reg, width_next;
    logic [31:0]            height_reg, height_next;
    logic [15:0]            depth_reg, depth_next;
    logic [31:0]            comp_reg, comp_next;
    logic [31:0]            colors_reg, colors_next;
    logic [1:0]             idx_reg, idx_next;
    logic [7:0]             blue_reg, blue_next;
    logic [7:0]             green_reg, green_next;
    logic [8:0]             entries_reg, entries_next;
    logic                   color_reg, color_next;

    logic             cur_small;
    logic [5:0]       lo;
    logic             is_core, is_info;
    logic             depth_ok;
    logic [8:0]       pal_size;
    logic [31:0]      colors_eff;
    logic             comp_pal;
    logic             info_plan;
    logic             plan_ok;
    logic [CMP_W-1:0] cur_ext, pal_start;
    logic             start_ok;
    logic [8:0]       pal_count;
    logic             scan;
    logic             entry_done;

    assign cur_small = (offset_reg[OFFSET_BITS-1:6] == '0);
    assign lo        = offset_reg[5:0];
    assign is_core   = (hl_reg == bhp_pkg::HDR_CORE);
    assign is_info   = (hl_reg >= bhp_pkg::HDR_INFO_MIN);

    // Palette plan; header fields are settled well before the palette starts
    assign depth_ok   = (depth_reg <= bhp_pkg::PAL_MAX_DEPTH);
    assign pal_size   = 9'd1 << depth_reg[3:0];
    assign colors_eff = (colors_reg == '0) ? 32'(pal_size) : colors_reg;
    assign comp_pal   = (comp_reg == bhp_pkg::COMP_RGB) || (comp_reg == bhp_pkg::COMP_RLE8);
    assign info_plan  = is_info && comp_pal && (colors_eff <= 32'(pal_size));
    assign plan_ok    = depth_ok && (is_core || info_plan);
    assign cur_ext    = CMP_W'(offset_reg);
    assign pal_start  = CMP_W'(hl_reg) + CMP_W'(bhp_pkg::INFO_PAL_BASE);
    assign start_ok   = is_core ? (!cur_small || lo >= bhp_pkg::OFS_CORE_PAL)
                                : (cur_ext >= pal_start);
    assign pal_count  = is_core ? pal_size : colors_eff[8:0];
    assign scan       = plan_ok && start_ok && (entries_reg < pal_count);
    assign entry_done = is_core ? (idx_reg == 2'd2) : (idx_reg == 2'd3);

    always_comb
    begin
        sig_next     = sig_reg;
        hl_next      = hl_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        depth_next   = depth_reg;
        comp_next    = comp_reg;
        colors_next  = colors_reg;
        idx_next     = idx_reg;
        blue_next    = blue_reg;
        green_next   = green_reg;
        entries_next = entries_reg;
        color_next   = color_reg;

        if (offset_reg == '0)
        begin
            sig_next = (data_byte == bhp_pkg::SIG_B);
        end
        else if (cur_small && lo == 6'd1)
        begin
            sig_next = sig_reg && (data_byte == bhp_pkg::SIG_M);
        end

        if (cur_small)
        begin
            unique case (lo)
                bhp_pkg::OFS_HDR_SIZE0: hl_next[7:0]   = data_byte;
                bhp_pkg::OFS_HDR_SIZE1: hl_next[15:8]  = data_byte;
                bhp_pkg::OFS_HDR_SIZE2: hl_next[23:16] = data_byte;
                bhp_pkg::OFS_HDR_SIZE3: hl_next[31:24] = data_byte;
                bhp_pkg::OFS_FIELD18:
                begin
                    if (is_core || is_info) width_next[7:0] = data_byte;
                end
                bhp_pkg::OFS_FIELD19:
                begin
                    if (is_core || is_info) width_next[15:8] = data_byte;
                end
                bhp_pkg::OFS_FIELD20:
                begin
                    if (is_core)      height_next[7:0]  = data_byte;
                    else if (is_info) width_next[23:16] = data_byte;
                end
                bhp_pkg::OFS_FIELD21:
                begin
                    if (is_core)      height_next[15:8] = data_byte;
                    else if (is_info) width_next[31:24] = data_byte;
                end
                bhp_pkg::OFS_FIELD22:
                begin
                    if (is_info) height_next[7:0] = data_byte;
                end
                bhp_pkg::OFS_FIELD23:
                begin
                    if (is_info) height_next[15:8] = data_byte;
                end
                bhp_pkg::OFS_FIELD24:
                begin
                    if (is_core)      depth_next[7:0]    = data_byte;
                    else if (is_info) height_next[23:16] = data_byte;
                end
                bhp_pkg::OFS_FIELD25:
                begin
                    if (is_core)      depth_next[15:8]   = data_byte;
                    else if (is_info) height_next[31:24] = data_byte;
                end
                bhp_pkg::OFS_DEPTH0:
                begin
                    if (is_info) depth_next[7:0] = data_byte;
                end
                bhp_pkg::OFS_DEPTH1:
                begin
                    if (is_info) depth_next[15:8] = data_byte;
                end
                bhp_pkg::OFS_COMP0:
                begin
                    if (is_info) comp_next[7:0] = data_byte;
                end
                bhp_pkg::OFS_COMP1:
                begin
                    if (is_info) comp_next[15:8] = data_byte;
                end
                bhp_pkg::OFS_COMP2:
                begin
                    if (is_info) comp_next[23:16] = data_byte;
                end
                bhp_pkg::OFS_COMP3:
                begin
                    if (is_info) comp_next[31:24] = data_byte;
                end
                bhp_pkg::OFS_COLORS0:
                begin
                    if (is_info) colors_next[7:0] = data_byte;
                end
                bhp_pkg::OFS_COLORS1:
                begin
                    if (is_info) colors_next[15:8] = data_byte;
                end
                bhp_pkg::OFS_COLORS2:
                begin
                    if (is_info) colors_next[23:16] = data_byte;
                end
                bhp_pkg::OFS_COLORS3:
                begin
                    if (is_info) colors_next[31:24] = data_byte;
                end
                default: ;
            endcase
        end

        // Judge each palette entry once blue, green and red are in
        if (scan)
        begin
            unique case (idx_reg)
                2'd0: blue_next  = data_byte;
                2'd1: green_next = data_byte;
                2'd2:
                begin
                    if (blue_reg != green_reg || blue_reg != data_byte)
                        color_next = 1'b1;
                end
                default: ;
            endcase
            if (entry_done)
            begin
                idx_next     = 2'd0;
                entries_next = entries_reg + 9'd1;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end

        // Hold at the top offset once reached
        offset_next = (offset_reg == '1) ? offset_reg : offset_reg + 1'b1;
    end

    always_comb
    begin
        snap.signature_ok     = sig_next;
        snap.header_length    = hl_next;
        snap.width_word       = width_next;
        snap.height_word      = height_next;
        snap.depth_word       = depth_next;
        snap.compression_word = comp_next;
        snap.colors_word      = colors_next;
        snap.color_seen       = color_next;
        snap.len_ge18         = !cur_small || (lo >= bhp_pkg::OFS_MIN_LEN);
        snap.len_ge26         = !cur_small || (lo >= bhp_pkg::OFS_CORE_LEN);
        snap.len_ge50         = !cur_small || (lo >= bhp_pkg::OFS_INFO_LEN);
    end

    // Clear everything after the final byte so the next file starts fresh
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            sig_reg     <= 1'b0;
            hl_reg      <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            depth_reg   <= '0;
            comp_reg    <= '0;
            colors_reg  <= '0;
            idx_reg     <= '0;
            blue_reg    <= '0;
            green_reg   <= '0;
            entries_reg <= '0;
            color_reg   <= 1'b0;
        end
        else if (fire)
        begin
            if (last)
            begin
                offset_reg  <= '0;
                sig_reg     <= 1'b0;
                hl_reg      <= '0;
                width_reg   <= '0;
                height_reg  <= '0;
                depth_reg   <= '0;
                comp_reg    <= '0;
                colors_reg  <= '0;
                idx_reg     <= '0;
                blue_reg    <= '0;
                green_reg   <= '0;
                entries_reg <= '0;
                color_reg   <= 1'b0;
            end
            else
            begin
                offset_reg  <= offset_next;
                sig_reg     <= sig_next;
                hl_reg      <= hl_next;
                width_reg   <= width_next;
                height_reg  <= height_next;
                depth_reg   <= depth_next;
                comp_reg    <= comp_next;
                colors_reg  <= colors_next;
                idx_reg     <= idx_next;
                blue_reg    <= blue_next;
                green_reg   <= green_next;
                entries_reg <= entries_next;
                color_reg   <= color_next;
            end
        end
    end

endmodule

FILE: hdl/bhp_result.sv
// Result decode (header kind, sizes, channel count) and the output register.
// Depends on bhp_pkg; instantiated by bmp_header_parser_top.

module bhp_result (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  bhp_pkg::bhp_snap_t   snap,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bhp_pkg::bhp_result_t out_item
);

    logic                 valid_reg, valid_next;
    bhp_pkg::bhp_result_t item_reg;
    bhp_pkg::bhp_result_t item_next;

    logic        kind_core, kind_info;
    logic [15:0] bpp;
    logic [31:0] comp;
    logic [31:0] ncolors;
    logic [8:0]  pal_size;
    logic        pal_depth;
    logic        colored;
    logic        comp_pal;
    logic [2:0]  ch;

    assign kind_core = (snap.header_length == bhp_pkg::HDR_CORE) && snap.len_ge26;
    assign kind_info = !kind_core && (snap.header_length >= bhp_pkg::HDR_INFO_MIN)
                       && snap.len_ge50;

    assign bpp       = (kind_core || kind_info) ? snap.depth_word : '0;
    assign comp      = kind_info ? snap.compression_word : '0;
    assign pal_depth = (bpp <= bhp_pkg::PAL_MAX_DEPTH);
    assign pal_size  = 9'd1 << bpp[3:0];
    assign colored   = (kind_core || kind_info) && snap.color_seen;
    assign comp_pal  = (comp == bhp_pkg::COMP_RGB) || (comp == bhp_pkg::COMP_RLE8);

    always_comb
    begin
        if (kind_core)
            ncolors = pal_depth ? 32'(pal_size) : '0;
        else if (kind_info)
            ncolors = (pal_depth && snap.colors_word == '0) ? 32'(pal_size) : snap.colors_word;
        else
            ncolors = '0;
    end

    always_comb
    begin
        ch = bhp_pkg::CH_NONE;
        if (comp_pal)
        begin
            priority if (pal_depth && ncolors <= 32'(pal_size))
                ch = colored ? bhp_pkg::CH_RGB : bhp_pkg::CH_GRAY;
            else if (bpp == bhp_pkg::BPP_24)
                ch = bhp_pkg::CH_RGB;
            else if (bpp == bhp_pkg::BPP_32)
                ch = bhp_pkg::CH_RGBA;
            else
                ch = bhp_pkg::CH_NONE;
        end
        else if (comp == bhp_pkg::COMP_BITFIELDS)
        begin
            if (bpp == bhp_pkg::BPP_16)
                ch = bhp_pkg::CH_RGB;
            else if (bpp == bhp_pkg::BPP_32)
                ch = bhp_pkg::CH_RGBA;
        end
    end

    always_comb
    begin
        item_next = '0;
        if (!snap.len_ge18)
        begin
            item_next.status = 1'b1;
        end
        else
        begin
            item_next.can_parse      = snap.signature_ok;
            item_next.bits_per_pixel = bpp;
            item_next.compression    = comp;
            item_next.channels       = ch;
            if (kind_core)
            begin
                item_next.header_kind  = bhp_pkg::KIND_CORE;
                item_next.image_width  = {16'd0, snap.width_word[15:0]};
                item_next.image_height = {16'd0, snap.height_word[15:0]};
            end
            else if (kind_info)
            begin
                // Magnitude of the signed sizes
                item_next.header_kind  = bhp_pkg::KIND_INFO;
                item_next.image_width  = snap.width_word[31] ? (32'd0 - snap.width_word)
                                                             : snap.width_word;
                item_next.image_height = snap.height_word[31] ? (32'd0 - snap.height_word)
                                                              : snap.height_word;
            end
            else
            begin
                item_next.header_kind = bhp_pkg::KIND_NONE;
            end
        end
    end

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: hdl/bmp_header_parser_top.sv
// BMP header parser top level: stream ports, field capture and result register.
// Depends on bhp_pkg, bhp_fields and bhp_result.
//
// Usage: stream a BMP file into the slave side one byte per transfer, with
// s_axis_tlast high on the final byte. Every byte updates the offset counter,
// the header fields and the palette scan in the cycle it is accepted. The
// final byte also loads one result into the output register; no other byte
// produces a result. The result appears on the master side in the cycle after
// the final byte is accepted and stays until it is taken.
// Throughput: one byte per cycle, set by the single register stage that holds
// the header state. s_axis_tready is high while the output register is empty
// or being emptied in the same cycle, so a new result can follow a taken one
// with no gap. While a result is held and the receiver stalls, s_axis_tready
// drops and every input byte waits until that result is taken.
// Reset clears the offset, the header state and the output valid. After the
// final byte of a file the offset and the header state are clear again, ready for the next.

module bmp_header_parser_top #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  logic                            s_axis_tlast,  // last
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] can_parse, [1] status, [3:2] header_kind, [35:4] image_width,
    // [67:36] image_height, [83:68] bits_per_pixel, [115:84] compression,
    // [118:116] channels, [119] zero
    output logic [bhp_pkg::TDATA_BITS-1:0]  m_axis_tdata
);

    logic                 s_fire;
    bhp_pkg::bhp_snap_t   snap;
    bhp_pkg::bhp_result_t res;

    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    bhp_fields #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_fields (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s_fire),
        .data_byte (s_axis_tdata),
        .last      (s_axis_tlast),
        .snap      (snap)
    );

    bhp_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s_fire && s_axis_tlast),
        .snap      (snap),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (res)
    );

    assign m_axis_tdata = bhp_pkg::TDATA_BITS'(res);

    // A final byte always yields a result in the next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_axis_tlast) |=> m_axis_tvalid)
        else $error("final byte produced no result");

    // Bytes other than the final one never create a result
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid && !(s_fire && s_axis_tlast)) |=> !m_axis_tvalid)
        else $error("result appeared without a final byte");

    // A short stream reports nothing but the status
    a_short_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.status) |->
            (!res.can_parse && res.header_kind == bhp_pkg::KIND_NONE
             && res.channels == bhp_pkg::CH_NONE))
        else $error("short stream result carries header data");

    // Input stalls only behind a held, stalled result
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a pending result");

    // Unsupported header kind reports zero sizes
    a_kind_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.header_kind == bhp_pkg::KIND_NONE) |->
            (res.image_width == '0 && res.image_height == '0 && res.compression == '0))
        else $error("unsupported header with non-zero fields");

endmodule
